// ----- rtl/xxtea_pkg.sv -----
// Shared constants, types and microcode layout for the XXTEA block cipher.
`default_nettype none

package xxtea_pkg;

    // Build-time shape of the cipher
    localparam int BLOCK_WORDS = 5;
    localparam int ROUND_COUNT = 6;

    // Effective length (2..8) and round count (at least 1)
    localparam int XX_WORDS  = (BLOCK_WORDS < 2) ? 2 : ((BLOCK_WORDS > 8) ? 8 : BLOCK_WORDS);
    localparam int XX_ROUNDS = (ROUND_COUNT < 1) ? 1 : ROUND_COUNT;

    // Words carried on the ports
    localparam int NIN = 5;

    // Request command codes
    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    localparam logic [31:0] DELTA        = 32'h9e3779b9;
    localparam logic [63:0] SUM_DEC_WIDE = 64'(XX_ROUNDS) * 64'(DELTA);
    localparam logic [31:0] SUM_DEC_INIT = SUM_DEC_WIDE[31:0];

    localparam int PC_W  = $clog2(2 * XX_WORDS);
    localparam int RND_W = $clog2(XX_ROUNDS + 1);

    typedef logic [31:0]          word_t;
    typedef word_t [3:0]          key_t;
    typedef word_t [NIN-1:0]      blk_t;
    typedef logic [PC_W-1:0]      pc_t;
    typedef logic [RND_W-1:0]     rnd_t;

    // Program layout: encrypt steps first, then decrypt steps
    localparam pc_t ENC_ENTRY = '0;
    localparam pc_t ENC_LAST  = PC_W'(XX_WORDS - 1);
    localparam pc_t DEC_ENTRY = PC_W'(XX_WORDS);
    localparam pc_t DEC_LAST  = PC_W'(2 * XX_WORDS - 1);

    localparam rnd_t RND_LAST = RND_W'(XX_ROUNDS - 1);

    // One control word of the microprogram
    typedef struct packed {
        logic [1:0] key_base;   // low bits of word position p
        logic       dec;        // subtract and rotate right
        logic       end_round;  // last step of a round: update sum, jump or finish
        pc_t        jump_tgt;   // round start
    } ucode_t;

    // Sequencer to datapath
    typedef struct packed {
        logic load;
        logic step;
    } dp_ctrl_t;

endpackage : xxtea_pkg

`default_nettype wire

// ----- rtl/xxtea_urom.sv -----
// Microprogram ROM: step address to control word.
`default_nettype none

module xxtea_urom (
    input  xxtea_pkg::pc_t    pc,
    output xxtea_pkg::ucode_t uc
);
    import xxtea_pkg::*;

    pc_t p_dec;

    // decrypt walks the words from last to first
    assign p_dec = DEC_LAST - pc;

    always_comb begin
        uc = '0;
        if (pc <= ENC_LAST) begin
            uc.key_base  = pc[1:0];
            uc.dec       = 1'b0;
            uc.end_round = (pc == ENC_LAST);
            uc.jump_tgt  = ENC_ENTRY;
        end else if (pc <= DEC_LAST) begin
            uc.key_base  = p_dec[1:0];
            uc.dec       = 1'b1;
            uc.end_round = (pc == DEC_LAST);
            uc.jump_tgt  = DEC_ENTRY;
        end
    end

endmodule : xxtea_urom

`default_nettype wire

// ----- rtl/xxtea_dpath.sv -----
// Datapath: rotating word ring, running sum, key store and one mix unit.
`default_nettype none

module xxtea_dpath (
    input  logic                aclk,
    input  xxtea_pkg::dp_ctrl_t ctrl,
    input  xxtea_pkg::ucode_t   uc,
    input  logic                cmd,
    input  xxtea_pkg::key_t     key,
    input  xxtea_pkg::blk_t     in_words,
    output xxtea_pkg::blk_t     out_words
);
    import xxtea_pkg::*;

    localparam int W_LAST = XX_WORDS - 1;

    word_t      ring_reg [XX_WORDS];
    word_t      ring_next [XX_WORDS];
    key_t       key_reg;
    word_t      sum_reg;
    word_t      sum_next;

    word_t      cur_w;
    word_t      y_w;
    word_t      z_w;
    word_t      kw;
    word_t      mix_a;
    word_t      mix_b;
    word_t      mix_c;
    word_t      mix_d;
    word_t      mix_w;
    word_t      upd_w;
    logic [1:0] ksel;

    // Encrypt works at ring[0] and rotates left; decrypt at ring[last], rotates right.
    assign cur_w = uc.dec ? ring_reg[W_LAST] : ring_reg[0];
    assign y_w   = uc.dec ? ring_reg[0] : ring_reg[(1 % XX_WORDS)];
    assign z_w   = uc.dec ? ring_reg[(XX_WORDS + W_LAST - 1) % XX_WORDS] : ring_reg[W_LAST];

    assign ksel  = uc.key_base ^ sum_reg[3:2];
    assign kw    = key_reg[ksel];

    assign mix_a = (z_w >> 5) ^ (y_w << 2);
    assign mix_b = (y_w >> 3) ^ (z_w << 4);
    assign mix_c = sum_reg ^ y_w;
    assign mix_d = kw ^ z_w;
    assign mix_w = (mix_a + mix_b) ^ (mix_c + mix_d);
    assign upd_w = uc.dec ? (cur_w - mix_w) : (cur_w + mix_w);

    always_comb begin
        for (int i = 0; i < XX_WORDS; i++) begin
            ring_next[i] = ring_reg[i];
            if (ctrl.load) begin
                ring_next[i] = (i < NIN) ? in_words[i % NIN] : '0;
            end else if (ctrl.step) begin
                if (uc.dec) begin
                    ring_next[i] = (i == 0) ? upd_w : ring_reg[(i + W_LAST) % XX_WORDS];
                end else begin
                    ring_next[i] = (i == W_LAST) ? upd_w : ring_reg[(i + 1) % XX_WORDS];
                end
            end
        end
    end

    always_comb begin
        sum_next = sum_reg;
        if (ctrl.load) begin
            sum_next = (cmd == CMD_DECRYPT) ? SUM_DEC_INIT : DELTA;
        end else if (ctrl.step && uc.end_round) begin
            sum_next = uc.dec ? (sum_reg - DELTA) : (sum_reg + DELTA);
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < XX_WORDS; i++) begin
            ring_reg[i] <= ring_next[i];
        end
        sum_reg <= sum_next;
        if (ctrl.load) begin
            key_reg <= key;
        end
    end

    // Words past the block length pass through untouched
    for (genvar gi = 0; gi < NIN; gi++) begin : g_out
        if (gi < XX_WORDS) begin : g_ring
            assign out_words[gi] = ring_reg[gi];
        end else begin : g_hold
            word_t hold_reg;
            always_ff @(posedge aclk) begin
                if (ctrl.load) begin
                    hold_reg <= in_words[gi];
                end
            end
            assign out_words[gi] = hold_reg;
        end
    end

endmodule : xxtea_dpath

`default_nettype wire

// ----- rtl/xxtea_block_cipher.sv -----
// Top level: XXTEA block cipher with microcoded sequencer and output register.
`default_nettype none

// XXTEA (Corrected Block TEA) on a five-word block, six full rounds, key
// supplied with every request. s_cmd = 0 encrypts, 1 decrypts; each request
// yields exactly one result on the m_ channel. A request passes through a
// load, 30 mix steps (one word per cycle, five words times six rounds, set
// by the single mix unit) and a move of the result into the output register.
// The result register is separate from the working state, so a new request
// is taken while the previous result still waits for m_ready. No state
// survives between requests.
module xxtea_block_cipher (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_cmd,
    input  xxtea_pkg::word_t   s_key0,
    input  xxtea_pkg::word_t   s_key1,
    input  xxtea_pkg::word_t   s_key2,
    input  xxtea_pkg::word_t   s_key3,
    input  xxtea_pkg::word_t   s_in_word0,
    input  xxtea_pkg::word_t   s_in_word1,
    input  xxtea_pkg::word_t   s_in_word2,
    input  xxtea_pkg::word_t   s_in_word3,
    input  xxtea_pkg::word_t   s_in_word4,

    output logic               m_valid,
    input  logic               m_ready,
    output xxtea_pkg::word_t   m_out_word0,
    output xxtea_pkg::word_t   m_out_word1,
    output xxtea_pkg::word_t   m_out_word2,
    output xxtea_pkg::word_t   m_out_word3,
    output xxtea_pkg::word_t   m_out_word4
);
    import xxtea_pkg::*;

    // Sequencer states, one-hot
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,   // waiting for a request
        ST_RUN  = 3'b010,   // stepping through the microprogram
        ST_DONE = 3'b100    // result ready, waiting for the output register
    } state_t;

    state_t   state_reg, state_next;
    pc_t      pc_reg, pc_next;
    rnd_t     rnd_reg, rnd_next;
    logic     m_valid_reg, m_valid_next;
    blk_t     out_reg;

    ucode_t   uc;
    dp_ctrl_t dp_ctrl;
    key_t     key_in;
    blk_t     blk_in;
    blk_t     blk_res;
    logic     s_take;
    logic     out_free;
    logic     out_load;

    assign key_in = {s_key3, s_key2, s_key1, s_key0};
    assign blk_in = {s_in_word4, s_in_word3, s_in_word2, s_in_word1, s_in_word0};

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_take   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign out_load = (state_reg == ST_DONE) && out_free;

    assign dp_ctrl.load = s_take;
    assign dp_ctrl.step = (state_reg == ST_RUN);

    xxtea_urom u_urom (
        .pc (pc_reg),
        .uc (uc)
    );

    xxtea_dpath u_dpath (
        .aclk      (aclk),
        .ctrl      (dp_ctrl),
        .uc        (uc),
        .cmd       (s_cmd),
        .key       (key_in),
        .in_words  (blk_in),
        .out_words (blk_res)
    );

    // Sequencer: step counter with a conditional jump back at each round end
    always_comb begin
        state_next = state_reg;
        pc_next    = pc_reg;
        rnd_next   = rnd_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_take) begin
                    state_next = ST_RUN;
                    pc_next    = (s_cmd == CMD_DECRYPT) ? DEC_ENTRY : ENC_ENTRY;
                    rnd_next   = '0;
                end
            end
            ST_RUN: begin
                if (uc.end_round) begin
                    if (rnd_reg == RND_LAST) begin
                        state_next = ST_DONE;
                    end else begin
                        rnd_next = rnd_reg + 1'b1;
                        pc_next  = uc.jump_tgt;
                    end
                end else begin
                    pc_next = pc_reg + 1'b1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register valid flag
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pc_reg      <= '0;
            rnd_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pc_reg      <= pc_next;
            rnd_reg     <= rnd_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_reg <= blk_res;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_word0 = out_reg[0];
    assign m_out_word1 = out_reg[1];
    assign m_out_word2 = out_reg[2];
    assign m_out_word3 = out_reg[3];
    assign m_out_word4 = out_reg[4];

endmodule : xxtea_block_cipher

`default_nettype wire
